FILE: hdl/tlbr_pkg.sv
package tlbr_pkg;

  localparam int CHARS_PER_ROW = 16;
  localparam int ROW_COUNT     = 4;
  localparam int BUF_DEPTH     = 64;
  localparam int CELL_COUNT    = (CHARS_PER_ROW * ROW_COUNT > BUF_DEPTH) ?
                                 BUF_DEPTH : CHARS_PER_ROW * ROW_COUNT;
  localparam int ADDR_W        = $clog2(BUF_DEPTH);
  localparam int COL_W         = $clog2(CHARS_PER_ROW);
  localparam int ROW_W         = 2;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [7:0] SPACE_CODE       = 8'h20;
  localparam logic [7:0] CMD_SYNC_RESET   = 8'hF8;
  localparam logic [7:0] DATA_SYNC_RESET  = 8'hFA;

  // register indexes of the configuration port
  localparam logic CFG_COMMAND_SYNC = 1'b0;
  localparam logic CFG_DATA_SYNC    = 1'b1;

  // host operation codes
  localparam logic [1:0] OP_WRITE_CHAR = 2'd0;
  localparam logic [1:0] OP_CLEAR_ALL  = 2'd1;
  localparam logic [1:0] OP_CLEAR_LINE = 2'd2;
  localparam logic [1:0] OP_REFRESH    = 2'd3;

  typedef enum logic [1:0] {
    CMD_WRITE      = 2'd0,
    CMD_CLEAR_ALL  = 2'd1,
    CMD_CLEAR_LINE = 2'd2,
    CMD_REFRESH    = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e              kind;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        character;
    logic [ROW_W-1:0]  row;
  } cmd_t;

  // row address commands (0x80, 0x90, 0x88, 0x98)
  localparam logic [7:0] ROW_CMD [4] = '{8'h80, 8'h90, 8'h88, 8'h98};

endpackage

FILE: hdl/tlbr_front.sv
module tlbr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    opcode_i,
  input  logic [5:0]    address_i,
  input  logic [7:0]    character_i,
  input  logic [2:0]    line_number_i,
  output logic          q_valid_o,
  output tlbr_pkg::cmd_t q_cmd_o,
  input  logic          q_pop_i
);
  import tlbr_pkg::*;

  cmd_t       slot_q [QUEUE_DEPTH];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       accept, keep, push;
  cmd_t       cmd;

  always_comb begin
    cmd           = '0;
    keep          = 1'b1;
    cmd.addr      = address_i;
    cmd.character = character_i;
    cmd.row       = ROW_W'(line_number_i - 3'd1);
    unique case (opcode_i)
      OP_WRITE_CHAR: begin
        cmd.kind = CMD_WRITE;
        keep     = 7'(address_i) < 7'(CELL_COUNT);
      end
      OP_CLEAR_ALL: begin
        cmd.kind = CMD_CLEAR_ALL;
      end
      OP_CLEAR_LINE: begin
        cmd.kind = CMD_CLEAR_LINE;
        keep     = (line_number_i != 3'd0) && (32'(line_number_i) <= ROW_COUNT);
      end
      default: begin
        cmd.kind = CMD_REFRESH;
      end
    endcase
  end

  assign in_ready_o = count_q != 2'(QUEUE_DEPTH);
  assign accept     = in_valid_i && in_ready_o;
  // drop ignored operations here, they change nothing
  assign push       = accept && keep;
  assign q_valid_o  = count_q != 2'd0;
  assign q_cmd_o    = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule

FILE: hdl/tlbr_back.sv
module tlbr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  tlbr_pkg::cmd_t q_cmd_i,
  output logic           q_pop_o,
  input  logic           cfg_wr_en_i,
  input  logic           cfg_index_i,
  input  logic [7:0]     cfg_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           has_address_frame_o,
  output logic [23:0]    address_frame_o,
  output logic [23:0]    data_frame_o,
  output logic           last_o
);
  import tlbr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_LOAD = 4'b0100,
    ST_SEND = 4'b1000
  } state_e;

  state_e                 state_q;
  logic [ADDR_W-1:0]      cnt_q;
  logic [COL_W-1:0]       col_q;
  logic [ROW_W-1:0]       row_q;
  logic                   pending_q;
  logic [BUF_DEPTH-1:0]   valid_q;
  logic [BUF_DEPTH-1:0]   line_mask;
  logic [7:0]             cmd_sync_q, data_sync_q;
  logic [7:0]             mem_q [BUF_DEPTH];
  logic [7:0]             rd_data_q;
  logic                   rd_valid_q;
  logic                   mem_we;
  logic                   cell_last;
  logic                   out_take;
  logic [7:0]             line_start;
  logic [7:0]             ch;
  logic [7:0]             row_cmd;

  assign q_pop_o   = (state_q == ST_IDLE) && q_valid_i;
  assign mem_we    = q_pop_o && (q_cmd_i.kind == CMD_WRITE);
  assign cell_last = cnt_q == ADDR_W'(CELL_COUNT - 1);
  assign out_valid_o = state_q == ST_SEND;
  assign out_take  = out_valid_o && out_ready_i;

  always_comb begin
    line_start = 8'(32'(q_cmd_i.row) * CHARS_PER_ROW);
    for (int i = 0; i < BUF_DEPTH; i++) begin
      line_mask[i] = (9'(i) >= 9'(line_start)) &&
                     (9'(i) < 9'(line_start) + 9'(CHARS_PER_ROW));
    end
  end

  // buffer, single read port at the refresh counter
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[q_cmd_i.addr] <= q_cmd_i.character;
    end
    rd_data_q  <= mem_q[cnt_q];
    rd_valid_q <= valid_q[cnt_q];
  end

  assign ch      = rd_valid_q ? rd_data_q : SPACE_CODE;
  assign row_cmd = ROW_CMD[row_q];

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD) begin
      has_address_frame_o <= col_q == '0;
      address_frame_o     <= (col_q == '0) ?
                             {cmd_sync_q, row_cmd[7:4], 4'h0, row_cmd[3:0], 4'h0} :
                             24'h0;
      data_frame_o        <= {data_sync_q, ch[7:4], 4'h0, ch[3:0], 4'h0};
      last_o              <= cell_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      pending_q   <= 1'b1;
      valid_q     <= '0;
      cmd_sync_q  <= CMD_SYNC_RESET;
      data_sync_q <= DATA_SYNC_RESET;
    end else begin
      if (cfg_wr_en_i) begin
        case (cfg_index_i)
          CFG_COMMAND_SYNC: cmd_sync_q  <= cfg_data_i;
          default:          data_sync_q <= cfg_data_i;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (q_pop_o) begin
            unique case (q_cmd_i.kind)
              CMD_WRITE: begin
                valid_q[q_cmd_i.addr] <= 1'b1;
                pending_q             <= 1'b1;
              end
              CMD_CLEAR_ALL: begin
                valid_q   <= '0;
                pending_q <= 1'b1;
              end
              CMD_CLEAR_LINE: begin
                valid_q   <= valid_q & ~line_mask;
                pending_q <= 1'b1;
              end
              default: begin
                // tick with nothing pending: drop
                if (pending_q) begin
                  cnt_q   <= '0;
                  col_q   <= '0;
                  row_q   <= '0;
                  state_q <= ST_READ;
                end
              end
            endcase
          end
        end
        ST_READ: state_q <= ST_LOAD;
        ST_LOAD: state_q <= ST_SEND;
        ST_SEND: begin
          if (out_ready_i) begin
            if (cell_last) begin
              pending_q <= 1'b0;
              state_q   <= ST_IDLE;
            end else begin
              cnt_q <= cnt_q + ADDR_W'(1);
              if (col_q == COL_W'(CHARS_PER_ROW - 1)) begin
                col_q <= '0;
                row_q <= row_q + ROW_W'(1);
              end else begin
                col_q <= col_q + COL_W'(1);
              end
              state_q <= ST_READ;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_pending_in_refresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q)
    else $error("refresh running without pending flag");

  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && last_o) |=> !out_valid_o && !pending_q)
    else $error("frames continue after last");

  a_no_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_address_frame_o) |-> address_frame_o == 24'h0)
    else $error("address frame not zero");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !q_pop_o)
    else $error("queue popped during refresh");

endmodule

FILE: hdl/text_lcd_buffer_refresh_core.sv
// A host item enters the queue at acceptance and takes effect in the buffer when it is
// popped, after any item ahead of it, or once the last frame is taken when a refresh runs
// ahead of it; items are accepted one a cycle while the 2-entry queue has room.
// Non-refresh commands retire one a cycle while no refresh runs; a refresh tick with the
// pending flag set emits 64 frames, each through READ, LOAD and SEND in turn, as the buffer
// has a single read port. Reset (async, active low) marks all cells as spaces at once,
// sets the pending flag and loads sync bytes 0xF8 and 0xFA; no clearing pass.
module text_lcd_buffer_refresh_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [5:0]  address_i,
  input  logic [7:0]  character_i,
  input  logic [2:0]  line_number_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        has_address_frame_o,
  output logic [23:0] address_frame_o,
  output logic [23:0] data_frame_o,
  output logic        last_o,
  input  logic        cfg_wr_en_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import tlbr_pkg::*;

  logic q_valid, q_pop;
  cmd_t q_cmd;

  tlbr_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .opcode_i,
    .address_i,
    .character_i,
    .line_number_i,
    .q_valid_o (q_valid),
    .q_cmd_o   (q_cmd),
    .q_pop_i   (q_pop)
  );

  tlbr_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .q_pop_o   (q_pop),
    .cfg_wr_en_i,
    .cfg_index_i,
    .cfg_data_i,
    .out_valid_o,
    .out_ready_i,
    .has_address_frame_o,
    .address_frame_o,
    .data_frame_o,
    .last_o
  );

endmodule

FILE: sim/tb_text_lcd_buffer_refresh_core.sv
module tb_text_lcd_buffer_refresh_core;
  import tlbr_pkg::*;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int PHASE_ITEMS     = 130;

  localparam logic [7:0] ROW_ADDR_CMD [4] = '{8'h80, 8'h90, 8'h88, 8'h98};

  typedef struct packed {
    cmd_e        kind;
    logic [5:0]  addr;
    logic [7:0]  char_code;
    logic [2:0]  line;
    logic        typed;
    logic        first_has_addr;
    logic [23:0] first_addr_frame;
    logic [23:0] first_data_frame;
  } host_op_t;

  typedef struct packed {
    logic        has_addr;
    logic [23:0] addr_frame;
    logic [23:0] data_frame;
    logic        last;
  } lcd_frame_t;

  // typed first frames only where the buffer content is obvious under reset sync bytes
  localparam host_op_t DIRECTED_OPS [24] = '{
    '{CMD_REFRESH,    6'd0,  8'h00, 3'd0, 1'b1, 1'b1, 24'hF88000, 24'hFA2000},
    '{CMD_REFRESH,    6'd63, 8'hFF, 3'd7, 1'b0, 1'b0, 24'h0,      24'h0},
    '{CMD_WRITE,      6'd0,  8'hFF, 3'd0, 1'b0, 1'b0, 24'h0,      24'h0},
    '{CMD_WRITE,      6'd63, 8'h00, 3'd7, 1'b0, 1'b0, 24'h0,      24'h0},
    '{CMD_WRITE,      6'd17, 8'hA5, 3'd2, 1'b0, 1'b0, 24'h0,      24'h0},
    '{CMD_WRITE,      6'd42, 8'h5A, 3'd5, 1'b0, 1'b0, 24'h0,      24'h0},
    '{CMD_REFRESH,    6'd0,  8'h00, 3'd0, 1'b1, 1'b1, 24'hF88000, 24'hFAF0F0},
    '{CMD_CLEAR_LINE, 6'd0,  8'h00, 3'd0, 1'b0, 1'b0, 24'h0,      24'h0},
    '{CMD_CLEAR_LINE, 6'd63, 8'hFF, 3'd5, 1'b0, 1'b0, 24'h0,      24'h0},
    '{CMD_CLEAR_LINE, 6'd21, 8'h33, 3'd6, 1'b0, 1'b0, 24'h0,      24'h0},
    '{CMD_CLEAR_LINE, 6'd42, 8'hCC, 3'd7, 1'b0, 1'b0, 24'h0,      24'h0},
    '{CMD_REFRESH,    6'd0,  8'h00, 3'd0, 1'b0, 1'b0, 24'h0,      24'h0},
    '{CMD_CLEAR_LINE, 6'd0,  8'h00, 3'd1, 1'b0, 1'b0, 24'h0,      24'h0},
    '{CMD_REFRESH,    6'd0,  8'h00, 3'd0, 1'b1, 1'b1, 24'hF88000, 24'hFA2000},
    '{CMD_WRITE,      6'd16, 8'h3C, 3'd0, 1'b0, 1'b0, 24'h0,      24'h0},
    '{CMD_WRITE,      6'd32, 8'hC3, 3'd0, 1'b0, 1'b0, 24'h0,      24'h0},
    '{CMD_WRITE,      6'd48, 8'h81, 3'd0, 1'b0, 1'b0, 24'h0,      24'h0},
    '{CMD_CLEAR_LINE, 6'd0,  8'h00, 3'd4, 1'b0, 1'b0, 24'h0,      24'h0},
    '{CMD_CLEAR_LINE, 6'd0,  8'h00, 3'd2, 1'b0, 1'b0, 24'h0,      24'h0},
    '{CMD_REFRESH,    6'd0,  8'h00, 3'd0, 1'b0, 1'b0, 24'h0,      24'h0},
    '{CMD_CLEAR_LINE, 6'd0,  8'h00, 3'd3, 1'b0, 1'b0, 24'h0,      24'h0},
    '{CMD_WRITE,      6'd5,  8'h7E, 3'd0, 1'b0, 1'b0, 24'h0,      24'h0},
    '{CMD_CLEAR_ALL,  6'd63, 8'hFF, 3'd7, 1'b0, 1'b0, 24'h0,      24'h0},
    '{CMD_REFRESH,    6'd0,  8'h00, 3'd0, 1'b1, 1'b1, 24'hF88000, 24'hFA2000}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  opcode_i;
  logic [5:0]  address_i;
  logic [7:0]  character_i;
  logic [2:0]  line_number_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        has_address_frame_o;
  logic [23:0] address_frame_o;
  logic [23:0] data_frame_o;
  logic        last_o;
  logic        cfg_wr_en_i;
  logic        cfg_index_i;
  logic [7:0]  cfg_data_i;

  logic [7:0]  shadow_text [BUF_DEPTH];
  logic        refresh_due;
  logic [7:0]  cmd_sync_cfg;
  logic [7:0]  data_sync_cfg;
  lcd_frame_t  pending_frames [$];

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_toggle;
  int  fail_count;
  int  items_sent;
  int  frames_checked;
  int  refresh_bursts;
  int  stall_cycles;

  text_lcd_buffer_refresh_core dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .opcode_i            (opcode_i),
    .address_i           (address_i),
    .character_i         (character_i),
    .line_number_i       (line_number_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .has_address_frame_o (has_address_frame_o),
    .address_frame_o     (address_frame_o),
    .data_frame_o        (data_frame_o),
    .last_o              (last_o),
    .cfg_wr_en_i         (cfg_wr_en_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [23:0] frame_bytes(input logic [7:0] sync, input logic [7:0] v);
    return {sync, v & 8'hF0, v[3:0], 4'h0};
  endfunction

  // update the shadow buffer and queue the frames this item causes
  task automatic predict_frames(input host_op_t op);
    lcd_frame_t f;
    int         start;
    int         row;
    case (op.kind)
      CMD_WRITE: begin
        if (op.addr < CELL_COUNT) begin
          shadow_text[op.addr] = op.char_code;
          refresh_due = 1'b1;
        end
      end
      CMD_CLEAR_ALL: begin
        foreach (shadow_text[k]) shadow_text[k] = SPACE_CODE;
        refresh_due = 1'b1;
      end
      CMD_CLEAR_LINE: begin
        if (op.line >= 1 && op.line <= ROW_COUNT) begin
          start = (int'(op.line) - 1) * CHARS_PER_ROW;
          for (int k = 0; k < CHARS_PER_ROW; k++)
            if (start + k < CELL_COUNT) shadow_text[start + k] = SPACE_CODE;
          refresh_due = 1'b1;
        end
      end
      default: begin
        if (refresh_due) begin
          for (int k = 0; k < CELL_COUNT; k++) begin
            row          = k / CHARS_PER_ROW;
            f.has_addr   = (k % CHARS_PER_ROW == 0) && (row < 4);
            f.addr_frame = f.has_addr ? frame_bytes(cmd_sync_cfg, ROW_ADDR_CMD[row % 4]) : '0;
            f.data_frame = frame_bytes(data_sync_cfg, shadow_text[k]);
            f.last       = (k + 1 == CELL_COUNT);
            pending_frames.push_back(f);
          end
          refresh_due = 1'b0;
          refresh_bursts++;
        end
      end
    endcase
  endtask

  function automatic host_op_t random_op();
    host_op_t op;
    int       pick;
    pick         = $urandom_range(99);
    op           = '0;
    op.kind      = (pick < 55) ? CMD_WRITE :
                   (pick < 70) ? CMD_CLEAR_LINE :
                   (pick < 75) ? CMD_CLEAR_ALL : CMD_REFRESH;
    op.addr      = 6'($urandom_range(63));
    op.char_code = 8'($urandom_range(255));
    op.line      = 3'($urandom_range(7));
    return op;
  endfunction

  task automatic send_op(input host_op_t op);
    int size_ahead;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op.kind;
    address_i     <= op.addr;
    character_i   <= op.char_code;
    line_number_i <= op.line;
    do @(posedge clk_i); while (!in_ready_o);
    size_ahead = pending_frames.size();
    predict_frames(op);
    if (op.typed && pending_frames.size() > size_ahead) begin
      pending_frames[size_ahead].has_addr   = op.first_has_addr;
      pending_frames[size_ahead].addr_frame = op.first_addr_frame;
      pending_frames[size_ahead].data_frame = op.first_data_frame;
    end
    items_sent++;
  endtask

  // hold the input off until every frame is out, then let queued host items retire
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_syncs(input logic [7:0] cmd_val, input logic [7:0] data_val);
    cfg_wr_en_i <= 1'b1;
    cfg_index_i <= CFG_COMMAND_SYNC;
    cfg_data_i  <= cmd_val;
    @(posedge clk_i);
    cfg_index_i <= CFG_DATA_SYNC;
    cfg_data_i  <= data_val;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    cmd_sync_cfg  = cmd_val;
    data_sync_cfg = data_val;
    @(posedge clk_i);
  endtask

  initial begin
    bit seen;
    seen        = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_toggle != seen) begin
        seen = hold_toggle;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    lcd_frame_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_frames.size() == 0) begin
        $error("frame with no expectation waiting: data_frame %06h", data_frame_o);
        fail_count++;
      end else begin
        want = pending_frames.pop_front();
        frames_checked++;
        if (has_address_frame_o !== want.has_addr) begin
          $error("has_address_frame: expected %0d, got %0d", want.has_addr, has_address_frame_o);
          fail_count++;
        end
        if (address_frame_o !== want.addr_frame) begin
          $error("address_frame: expected %06h, got %06h", want.addr_frame, address_frame_o);
          fail_count++;
        end
        if (data_frame_o !== want.data_frame) begin
          $error("data_frame: expected %06h, got %06h", want.data_frame, data_frame_o);
          fail_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $error("no handshake for %0d cycles, %0d frames outstanding", WATCHDOG_LIMIT,
             pending_frames.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [7:0] rand_cmd;
    logic [7:0] rand_data;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    opcode_i       = OP_WRITE_CHAR;
    address_i      = '0;
    character_i    = '0;
    line_number_i  = '0;
    cfg_wr_en_i    = 1'b0;
    cfg_index_i    = CFG_COMMAND_SYNC;
    cfg_data_i     = '0;
    hold_toggle    = 1'b0;
    fail_count     = 0;
    items_sent     = 0;
    frames_checked = 0;
    refresh_bursts = 0;
    stall_cycles   = 0;
    foreach (shadow_text[k]) shadow_text[k] = SPACE_CODE;
    refresh_due    = 1'b1;
    cmd_sync_cfg   = CMD_SYNC_RESET;
    data_sync_cfg  = DATA_SYNC_RESET;
    send_idle_pct  = 10;
    recv_idle_pct  = 86;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_OPS[i]) send_op(DIRECTED_OPS[i]);

    for (int ph = 0; ph < 3; ph++) begin
      drain_block();
      case (ph)
        0: write_syncs(8'h00, 8'hFF);
        1: begin
          send_idle_pct = 86;
          recv_idle_pct = 10;
          write_syncs(8'hFF, 8'h00);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          rand_cmd      = 8'($urandom_range(255));
          rand_data     = 8'($urandom_range(255));
          write_syncs(rand_cmd, rand_data);
          // stall the output while a refresh and further items pile up behind it
          hold_toggle <= ~hold_toggle;
          send_op(DIRECTED_OPS[2]);
          send_op(DIRECTED_OPS[1]);
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 1 && i == PHASE_ITEMS / 2) drain_block();
        send_op(random_op());
      end
    end

    drain_block();
    if (pending_frames.size() != 0) begin
      $error("%0d expected frames never arrived", pending_frames.size());
      fail_count++;
    end

    $display("Sent %0d host items; %0d refreshes produced %0d checked frames.",
             items_sent, refresh_bursts, frames_checked);
    $display("Sync bytes: reset, 00/FF, FF/00 and random; idle mixes on both sides.");
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: text_lcd_buffer_refresh_core.f
hdl/tlbr_pkg.sv
hdl/tlbr_front.sv
hdl/tlbr_back.sv
hdl/text_lcd_buffer_refresh_core.sv
sim/tb_text_lcd_buffer_refresh_core.sv
